[rtl/lscn_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscn_pkg
// shared types and constants of the line sensor calibrate and normalize unit
// ----------------------------------------------------------------------------
package lscn_pkg;

   localparam int LIGHT_BITS      = 8;
   localparam int QUOT_BITS       = 8;
   localparam int RESET_LEVEL_BITS = 10;
   localparam int CSR_INDEX_BITS  = 8;
   localparam int CSR_DATA_BITS   = 8;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_DARK_LEVEL    = 8'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_QUIET_TIMEOUT = 8'd1;

   localparam logic REQ_CALIBRATE = 1'b0;
   localparam logic REQ_MEASURE   = 1'b1;

   localparam logic [RESET_LEVEL_BITS-1:0] BLACK_RESET = 10'd850;
   localparam logic [RESET_LEVEL_BITS-1:0] WHITE_RESET = 10'd950;

   localparam logic [7:0] DARK_LEVEL_RESET     = 8'd100;
   localparam logic [7:0] QUIET_TIMEOUT_RESET  = 8'd20;
   localparam logic [7:0] TIMER_MAX            = 8'hff;
   localparam logic [LIGHT_BITS-1:0] LIGHT_MAX = 8'hff;
   localparam logic [LIGHT_BITS-1:0] LIGHT_MIN = 8'h00;

   localparam int MASK_LEFT_BLACK  = 0;
   localparam int MASK_RIGHT_BLACK = 1;
   localparam int MASK_LEFT_WHITE  = 2;
   localparam int MASK_RIGHT_WHITE = 3;
   localparam logic [3:0] MASK_ALL = 4'hf;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CALC,
      ST_PREP,
      ST_DIVIDE,
      ST_FINISH
   } lscn_state_type;

endpackage

[rtl/lscn_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscn channel interfaces
// request, response and register write channels with valid/ready transfer
// ----------------------------------------------------------------------------
interface lscn_req_if #(parameter int SAMPLE_BITS = 10);
   logic                   valid;
   logic                   ready;
   logic                   req_type;
   logic [SAMPLE_BITS-1:0] left_sample;
   logic [SAMPLE_BITS-1:0] right_sample;

   modport source (output valid, output req_type, output left_sample,
                   output right_sample, input ready);
   modport sink   (input valid, input req_type, input left_sample,
                   input right_sample, output ready);
endinterface

interface lscn_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] left_light;
   logic [7:0] right_light;
   logic       calibrated;
   logic       dark;

   modport source (output valid, output left_light, output right_light,
                   output calibrated, output dark, input ready);
   modport sink   (input valid, input left_light, input right_light,
                   input calibrated, input dark, output ready);
endinterface

interface lscn_csr_if;
   logic       valid;
   logic       ready;
   logic [7:0] index;
   logic [7:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/lscn_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lscn_div
// restoring divider, one quotient bit per cycle, 8-bit quotient
// ----------------------------------------------------------------------------
module lscn_div import lscn_pkg::*; #(
   parameter int DIVISOR_BITS = 10
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic [DIVISOR_BITS+QUOT_BITS-1:0] numer,
   input  logic [DIVISOR_BITS-1:0]           denom,
   output logic [QUOT_BITS-1:0]              quotient,
   output logic                              done
);

   localparam int STEP_BITS = $clog2(QUOT_BITS);
   localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(QUOT_BITS - 1);

   logic                    busy_ff,  busy_in;
   logic                    done_ff,  done_in;
   logic [STEP_BITS-1:0]    step_ff,  step_in;
   logic [DIVISOR_BITS-1:0] rem_ff,   rem_in;
   logic [DIVISOR_BITS-1:0] denom_ff, denom_in;
   logic [QUOT_BITS-1:0]    quot_ff,  quot_in;

   logic [DIVISOR_BITS:0]   trial;
   logic [DIVISOR_BITS:0]   trial_diff;
   logic                    trial_ge;

   always_comb begin
      trial      = {rem_ff, quot_ff[QUOT_BITS-1]};
      trial_ge   = trial >= {1'b0, denom_ff};
      trial_diff = trial - {1'b0, denom_ff};

      busy_in  = busy_ff;
      done_in  = 1'b0;
      step_in  = step_ff;
      rem_in   = rem_ff;
      denom_in = denom_ff;
      quot_in  = quot_ff;

      if (start) begin
         busy_in  = 1'b1;
         step_in  = '0;
         rem_in   = numer[DIVISOR_BITS+QUOT_BITS-1:QUOT_BITS];
         quot_in  = numer[QUOT_BITS-1:0];
         denom_in = denom;
      end else if (busy_ff) begin
         rem_in  = trial_ge ? trial_diff[DIVISOR_BITS-1:0] : trial[DIVISOR_BITS-1:0];
         quot_in = {quot_ff[QUOT_BITS-2:0], trial_ge};
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_LAST) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      rem_ff   <= rem_in;
      denom_ff <= denom_in;
      quot_ff  <= quot_in;
   end

   assign quotient = quot_ff;
   assign done     = done_ff;

endmodule

[rtl/line_sensor_calibrate_normalize_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// line_sensor_calibrate_normalize_unit
// two-channel line sensor conditioner: min/max calibration and normalization
//
// req_if carries one item per transfer: req_type (0 calibrate, 1 measure) and
// a left and right raw sample. every item gives exactly one rsp_if transfer
// with left_light, right_light, calibrated and dark.
// csr_if writes the dark level (index 0) and quiet_timeout (index 1); it is
// always ready, and writes are expected only while the unit is idle.
// one item at a time: req_if.ready is high only in the idle state.
// calibrate item: ST_CALC updates levels, mask and timer; ST_FINISH then
// loads the response register and returns to idle.
// measure item: each channel passes ST_PREP, which clamps the sample or
// starts the shared divider (start, 8 quotient bits, done) and waits in
// ST_DIVIDE; after the right channel, ST_FINISH loads the response register.
// the response sits in an output register, so the next item is taken while
// a response waits; a stalled receiver holds the unit in its final state.
// reset restores the levels (850 black, 950 white), the registers, clears
// the mask and timer and sets the held lights to 255.
// ----------------------------------------------------------------------------
module line_sensor_calibrate_normalize_unit import lscn_pkg::*; #(
   parameter int SAMPLE_BITS = 10
) (
   input  logic        clock,
   input  logic        reset,
   lscn_req_if.sink    req_if,
   lscn_rsp_if.source  rsp_if,
   lscn_csr_if.sink    csr_if
);

   localparam int LEVEL_BITS = (SAMPLE_BITS > RESET_LEVEL_BITS) ? SAMPLE_BITS : RESET_LEVEL_BITS;
   localparam int NUMER_BITS = LEVEL_BITS + QUOT_BITS;
   localparam logic [LEVEL_BITS-1:0] BLACK_INIT = LEVEL_BITS'(BLACK_RESET);
   localparam logic [LEVEL_BITS-1:0] WHITE_INIT = LEVEL_BITS'(WHITE_RESET);

   lscn_state_type state_ff, state_in;

   logic                  mode_ff,         mode_in;
   logic                  chan_ff,         chan_in;
   logic [LEVEL_BITS-1:0] left_sample_ff,  left_sample_in;
   logic [LEVEL_BITS-1:0] right_sample_ff, right_sample_in;
   logic [LEVEL_BITS-1:0] left_black_ff,   left_black_in;
   logic [LEVEL_BITS-1:0] left_white_ff,   left_white_in;
   logic [LEVEL_BITS-1:0] right_black_ff,  right_black_in;
   logic [LEVEL_BITS-1:0] right_white_ff,  right_white_in;
   logic [7:0]            timer_ff,        timer_in;
   logic [3:0]            mask_ff,         mask_in;
   logic [LIGHT_BITS-1:0] held_left_ff,    held_left_in;
   logic [LIGHT_BITS-1:0] held_right_ff,   held_right_in;
   logic                  cal_ff,          cal_in;
   logic [7:0]            threshold_ff,    threshold_in;
   logic [7:0]            timeout_ff,      timeout_in;
   logic                  rsp_valid_ff,    rsp_valid_in;
   logic [LIGHT_BITS-1:0] rsp_left_ff,     rsp_left_in;
   logic [LIGHT_BITS-1:0] rsp_right_ff,    rsp_right_in;
   logic                  rsp_cal_ff,      rsp_cal_in;
   logic                  rsp_dark_ff,     rsp_dark_in;

   logic [LEVEL_BITS-1:0] sel_sample;
   logic [LEVEL_BITS-1:0] sel_black;
   logic [LEVEL_BITS-1:0] sel_white;
   logic [LEVEL_BITS-1:0] span_num;
   logic [NUMER_BITS-1:0] div_numer;
   logic [LEVEL_BITS-1:0] div_denom;
   logic                  div_start;
   logic [QUOT_BITS-1:0]  div_quot;
   logic                  div_done;
   logic                  store_en;
   logic [LIGHT_BITS-1:0] store_val;
   logic                  ext_lb, ext_rb, ext_lw, ext_rw;
   logic [3:0]            mask_new;
   logic [7:0]            timer_new;

   lscn_div #(
      .DIVISOR_BITS (LEVEL_BITS)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .numer    (div_numer),
      .denom    (div_denom),
      .quotient (div_quot),
      .done     (div_done)
   );

   always_comb begin
      sel_sample = chan_ff ? right_sample_ff : left_sample_ff;
      sel_black  = chan_ff ? right_black_ff  : left_black_ff;
      sel_white  = chan_ff ? right_white_ff  : left_white_ff;
      span_num   = sel_sample - sel_black;
      div_numer  = {span_num, {QUOT_BITS{1'b0}}} - NUMER_BITS'(span_num);
      div_denom  = sel_white - sel_black;

      ext_lb    = left_sample_ff  < left_black_ff;
      ext_rb    = right_sample_ff < right_black_ff;
      ext_lw    = left_sample_ff  > left_white_ff;
      ext_rw    = right_sample_ff > right_white_ff;
      mask_new  = mask_ff;
      mask_new[MASK_LEFT_BLACK]  = mask_ff[MASK_LEFT_BLACK]  | ext_lb;
      mask_new[MASK_RIGHT_BLACK] = mask_ff[MASK_RIGHT_BLACK] | ext_rb;
      mask_new[MASK_LEFT_WHITE]  = mask_ff[MASK_LEFT_WHITE]  | ext_lw;
      mask_new[MASK_RIGHT_WHITE] = mask_ff[MASK_RIGHT_WHITE] | ext_rw;
      if (ext_lb || ext_rb || ext_lw || ext_rw) begin
         timer_new = 8'd1;
      end else if (timer_ff == TIMER_MAX) begin
         timer_new = TIMER_MAX;
      end else begin
         timer_new = timer_ff + 8'd1;
      end

      state_in        = state_ff;
      mode_in         = mode_ff;
      chan_in         = chan_ff;
      left_sample_in  = left_sample_ff;
      right_sample_in = right_sample_ff;
      left_black_in   = left_black_ff;
      left_white_in   = left_white_ff;
      right_black_in  = right_black_ff;
      right_white_in  = right_white_ff;
      timer_in        = timer_ff;
      mask_in         = mask_ff;
      held_left_in    = held_left_ff;
      held_right_in   = held_right_ff;
      cal_in          = cal_ff;
      threshold_in    = threshold_ff;
      timeout_in      = timeout_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_left_in     = rsp_left_ff;
      rsp_right_in    = rsp_right_ff;
      rsp_cal_in      = rsp_cal_ff;
      rsp_dark_in     = rsp_dark_ff;
      div_start       = 1'b0;
      store_en        = 1'b0;
      store_val       = LIGHT_MIN;

      if (csr_if.valid) begin
         unique case (csr_if.index)
            CSR_DARK_LEVEL:    threshold_in = csr_if.data;
            CSR_QUIET_TIMEOUT: timeout_in   = csr_if.data;
            default: ;
         endcase
      end

      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               mode_in         = req_if.req_type;
               chan_in         = 1'b0;
               left_sample_in  = LEVEL_BITS'(req_if.left_sample);
               right_sample_in = LEVEL_BITS'(req_if.right_sample);
               state_in        = (req_if.req_type == REQ_MEASURE) ? ST_PREP : ST_CALC;
            end
         end
         ST_CALC: begin
            if (ext_lb) left_black_in  = left_sample_ff;
            if (ext_rb) right_black_in = right_sample_ff;
            if (ext_lw) left_white_in  = left_sample_ff;
            if (ext_rw) right_white_in = right_sample_ff;
            mask_in  = mask_new;
            timer_in = timer_new;
            cal_in   = (mask_new == MASK_ALL) && (timer_new > timeout_ff);
            state_in = ST_FINISH;
         end
         ST_PREP: begin
            timer_in = '0;
            mask_in  = '0;
            cal_in   = 1'b1;
            if (sel_sample <= sel_black) begin
               store_en  = 1'b1;
               store_val = LIGHT_MIN;
            end else if (sel_sample >= sel_white) begin
               store_en  = 1'b1;
               store_val = LIGHT_MAX;
            end else begin
               div_start = 1'b1;
               state_in  = ST_DIVIDE;
            end
         end
         ST_DIVIDE: begin
            if (div_done) begin
               store_en  = 1'b1;
               store_val = div_quot;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_left_in  = held_left_ff;
               rsp_right_in = held_right_ff;
               rsp_cal_in   = cal_ff;
               rsp_dark_in  = (mode_ff == REQ_CALIBRATE) ||
                              (held_left_ff < threshold_ff) ||
                              (held_right_ff < threshold_ff);
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      if (store_en) begin
         if (chan_ff) begin
            held_right_in = store_val;
            state_in      = ST_FINISH;
         end else begin
            held_left_in = store_val;
            chan_in      = 1'b1;
            state_in     = ST_PREP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         left_black_ff  <= BLACK_INIT;
         left_white_ff  <= WHITE_INIT;
         right_black_ff <= BLACK_INIT;
         right_white_ff <= WHITE_INIT;
         timer_ff       <= '0;
         mask_ff        <= '0;
         held_left_ff   <= LIGHT_MAX;
         held_right_ff  <= LIGHT_MAX;
         threshold_ff   <= DARK_LEVEL_RESET;
         timeout_ff     <= QUIET_TIMEOUT_RESET;
         rsp_valid_ff   <= 1'b0;
         chan_ff        <= 1'b0;
         mode_ff        <= REQ_CALIBRATE;
         cal_ff         <= 1'b0;
      end else begin
         left_black_ff  <= left_black_in;
         left_white_ff  <= left_white_in;
         right_black_ff <= right_black_in;
         right_white_ff <= right_white_in;
         timer_ff       <= timer_in;
         mask_ff        <= mask_in;
         held_left_ff   <= held_left_in;
         held_right_ff  <= held_right_in;
         threshold_ff   <= threshold_in;
         timeout_ff     <= timeout_in;
         rsp_valid_ff   <= rsp_valid_in;
         chan_ff        <= chan_in;
         mode_ff        <= mode_in;
         cal_ff         <= cal_in;
      end
      left_sample_ff  <= left_sample_in;
      right_sample_ff <= right_sample_in;
      rsp_left_ff     <= rsp_left_in;
      rsp_right_ff    <= rsp_right_in;
      rsp_cal_ff      <= rsp_cal_in;
      rsp_dark_ff     <= rsp_dark_in;
   end

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign csr_if.ready       = 1'b1;
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.left_light  = rsp_left_ff;
   assign rsp_if.right_light = rsp_right_ff;
   assign rsp_if.calibrated  = rsp_cal_ff;
   assign rsp_if.dark        = rsp_dark_ff;

   // levels stay ordered, so the divisor is never zero
   a_left_order: assert property (@(posedge clock) disable iff (reset)
      left_black_ff < left_white_ff)
      else $error("left black level not below white level");

   a_right_order: assert property (@(posedge clock) disable iff (reset)
      right_black_ff < right_white_ff)
      else $error("right black level not below white level");

   a_uncal_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_cal_ff |-> rsp_dark_ff)
      else $error("uncalibrated response without dark");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIVIDE)
      else $error("divider finished outside the divide state");

   a_div_start: assert property (@(posedge clock) disable iff (reset)
      div_start |=> state_ff == ST_DIVIDE && !div_done)
      else $error("divider start not followed by divide state");

endmodule

[verif/tb_line_sensor_calibrate_normalize_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_line_sensor_calibrate_normalize_unit
// self-checking bench for the line sensor calibrate and normalize unit
//
// drives calibrate and measure items on the request channel and register
// writes on the csr channel. a behavioral copy of the unit predicts each
// response: black and white level tracking, extreme mask, quiet timer, linear
// scaling with clamping and the dark flag. a checker compares every response
// transfer field by field against the oldest prediction. directed items come
// first, then a long timer run, a receiver stall, random calibrate and measure
// sequences under several register settings, random idling, full range last.
// ----------------------------------------------------------------------------
module tb_line_sensor_calibrate_normalize_unit;
   import lscn_pkg::*;

   localparam int SAMPLE_BITS = 10;
   localparam logic [SAMPLE_BITS-1:0] SAMPLE_MAX = '1;

   typedef struct packed {
      logic [LIGHT_BITS-1:0] left_light;
      logic [LIGHT_BITS-1:0] right_light;
      logic                  calibrated;
      logic                  dark;
   } light_result_type;

   logic clock;
   logic reset;

   lscn_req_if #(.SAMPLE_BITS(SAMPLE_BITS)) req_bus ();
   lscn_rsp_if                              rsp_bus ();
   lscn_csr_if                              csr_bus ();

   line_sensor_calibrate_normalize_unit #(.SAMPLE_BITS(SAMPLE_BITS)) u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus),
      .csr_if (csr_bus)
   );

   // predicted unit state
   logic [SAMPLE_BITS-1:0] black_l, white_l, black_r, white_r;
   logic [7:0]             quiet_count;
   logic [3:0]             extreme_seen;
   logic [LIGHT_BITS-1:0]  held_l, held_r;
   logic [7:0]             cfg_dark_level;
   logic [7:0]             cfg_quiet_timeout;

   light_result_type expected_lights[$];
   int            mismatch_count = 0;
   int            items_sent = 0;
   int            rsp_hold_cycles = 0;
   bit            idle_on = 1'b1;
   bit            req_offered = 1'b0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("** line_sensor_calibrate_normalize_unit: FAILED **");
      $finish;
   end

   function automatic logic [LIGHT_BITS-1:0] scale_to_light(
      input logic [SAMPLE_BITS-1:0] s, blk, wht);
      int span;
      int offset;
      if (s <= blk) return LIGHT_MIN;
      if (s >= wht) return LIGHT_MAX;
      span = int'(wht) - int'(blk);
      offset = int'(s) - int'(blk);
      return LIGHT_BITS'((255 * offset) / span);
   endfunction

   function automatic light_result_type predict_lights(input logic typ,
      input logic [SAMPLE_BITS-1:0] l, r);
      light_result_type res;
      if (typ == REQ_CALIBRATE) begin
         if (l < black_l) begin
            black_l = l;
            quiet_count = '0;
            extreme_seen[MASK_LEFT_BLACK] = 1'b1;
         end
         if (r < black_r) begin
            black_r = r;
            quiet_count = '0;
            extreme_seen[MASK_RIGHT_BLACK] = 1'b1;
         end
         if (l > white_l) begin
            white_l = l;
            quiet_count = '0;
            extreme_seen[MASK_LEFT_WHITE] = 1'b1;
         end
         if (r > white_r) begin
            white_r = r;
            quiet_count = '0;
            extreme_seen[MASK_RIGHT_WHITE] = 1'b1;
         end
         if (quiet_count != TIMER_MAX) quiet_count = quiet_count + 8'd1;
         res.calibrated = (extreme_seen == MASK_ALL) && (quiet_count > cfg_quiet_timeout);
         res.dark = 1'b1;
      end else begin
         held_l = scale_to_light(l, black_l, white_l);
         held_r = scale_to_light(r, black_r, white_r);
         res.calibrated = 1'b1;
         res.dark = (held_l < cfg_dark_level) || (held_r < cfg_dark_level);
         quiet_count = '0;
         extreme_seen = '0;
      end
      res.left_light = held_l;
      res.right_light = held_r;
      return res;
   endfunction

   // sample near a channel's levels; widen pushes a level out by one
   function automatic logic [SAMPLE_BITS-1:0] level_sample(
      input logic [SAMPLE_BITS-1:0] blk, wht, input bit widen);
      int pick;
      pick = widen ? $urandom_range(0, 7) : 7;
      if (pick < 2 && blk != '0) return blk - 1'b1;
      if (pick >= 2 && pick < 4 && wht != SAMPLE_MAX) return wht + 1'b1;
      return SAMPLE_BITS'($urandom_range(int'(blk), int'(wht)));
   endfunction

   function automatic logic [SAMPLE_BITS-1:0] meas_sample(
      input logic [SAMPLE_BITS-1:0] blk, wht);
      case ($urandom_range(0, 3))
         0: return SAMPLE_BITS'($urandom_range(0, int'(SAMPLE_MAX)));
         1: return level_sample(blk, wht, 1'b0);
         2: return $urandom_range(0, 1) ? blk : wht;
         default: return level_sample(blk, wht, 1'b1);
      endcase
   endfunction

   task automatic note_mismatch(input string what, input int want, input int got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("[%0t] mismatch %s: expected %0d, got %0d", $realtime, what, want, got);
   endtask

   task automatic drop_req();
      if (req_offered) begin
         req_bus.valid <= 1'b0;
         req_offered = 1'b0;
      end
   endtask

   task automatic send_item(input logic typ, input logic [SAMPLE_BITS-1:0] l, r);
      int gap;
      gap = idle_on ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         drop_req();
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.req_type     <= typ;
      req_bus.left_sample  <= l;
      req_bus.right_sample <= r;
      req_offered = 1'b1;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_lights.push_back(predict_lights(typ, l, r));
      items_sent++;
   endtask

   task automatic wait_all_results();
      drop_req();
      while (expected_lights.size() != 0) @(posedge clock);
   endtask

   task automatic set_config(input logic [7:0] thresh, input logic [7:0] timeout);
      wait_all_results();
      csr_bus.valid <= 1'b1;
      csr_bus.index <= CSR_DARK_LEVEL;
      csr_bus.data  <= thresh;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      cfg_dark_level = thresh;
      csr_bus.index <= CSR_QUIET_TIMEOUT;
      csr_bus.data  <= timeout;
      do @(posedge clock); while (csr_bus.ready !== 1'b1);
      cfg_quiet_timeout = timeout;
      csr_bus.valid <= 1'b0;
   endtask

   // receiver: random stall per response, plus an optional long hold-off
   initial begin : rsp_ready_gen
      int stall;
      forever begin
         if (rsp_hold_cycles > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (rsp_hold_cycles) @(posedge clock);
            rsp_hold_cycles = 0;
         end
         stall = idle_on ? $urandom_range(0, 10) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1));
      end
   end

   always @(posedge clock) begin : response_check
      light_result_type want;
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_lights.size() == 0) begin
            note_mismatch("unexpected response transfer", 0, 1);
         end else begin
            want = expected_lights.pop_front();
            if (rsp_bus.left_light !== want.left_light)
               note_mismatch("left_light", want.left_light, rsp_bus.left_light);
            if (rsp_bus.right_light !== want.right_light)
               note_mismatch("right_light", want.right_light, rsp_bus.right_light);
            if (rsp_bus.calibrated !== want.calibrated)
               note_mismatch("calibrated", want.calibrated, rsp_bus.calibrated);
            if (rsp_bus.dark !== want.dark)
               note_mismatch("dark", want.dark, rsp_bus.dark);
         end
      end
   end

   // held lights after reset, clamping at the levels, values just inside them and the field extremes
   task automatic test_reset_outputs();
      send_item(REQ_CALIBRATE, level_sample(black_l, white_l, 1'b0),
                level_sample(black_r, white_r, 1'b0));
      send_item(REQ_MEASURE, black_l, white_r);
      send_item(REQ_MEASURE, black_l + 1'b1, white_r - 1'b1);
      send_item(REQ_MEASURE, '0, SAMPLE_MAX);
      send_item(REQ_MEASURE, SAMPLE_MAX, '0);
   endtask

   task automatic test_dark_level();
      set_config(8'd0, QUIET_TIMEOUT_RESET);
      send_item(REQ_MEASURE, '0, '0);
      send_item(REQ_MEASURE, SAMPLE_MAX, '0);
      set_config(8'hff, QUIET_TIMEOUT_RESET);
      send_item(REQ_MEASURE, SAMPLE_MAX, SAMPLE_MAX);
      send_item(REQ_MEASURE, white_l - 1'b1, SAMPLE_MAX);
      set_config(DARK_LEVEL_RESET, QUIET_TIMEOUT_RESET);
      send_item(REQ_MEASURE, black_l + 10'd40, white_r - 10'd40);
   endtask

   // all four extremes with zero timeout, then a measure clears the mask
   task automatic test_calibration_done();
      set_config(DARK_LEVEL_RESET, 8'd0);
      send_item(REQ_CALIBRATE, black_l - 1'b1, white_r + 1'b1);
      send_item(REQ_CALIBRATE, white_l + 1'b1, black_r - 1'b1);
      send_item(REQ_CALIBRATE, level_sample(black_l, white_l, 1'b0),
                level_sample(black_r, white_r, 1'b0));
      send_item(REQ_MEASURE, meas_sample(black_l, white_l), meas_sample(black_r, white_r));
      send_item(REQ_CALIBRATE, level_sample(black_l, white_l, 1'b0),
                level_sample(black_r, white_r, 1'b0));
   endtask

   // timer must stop at its top value: never done at timeout 255, done at 254
   task automatic test_timer_saturation();
      set_config(DARK_LEVEL_RESET, TIMER_MAX);
      send_item(REQ_CALIBRATE, black_l - 1'b1, white_r + 1'b1);
      send_item(REQ_CALIBRATE, white_l + 1'b1, black_r - 1'b1);
      repeat (260)
         send_item(REQ_CALIBRATE, level_sample(black_l, white_l, 1'b0),
                   level_sample(black_r, white_r, 1'b0));
      set_config(DARK_LEVEL_RESET, TIMER_MAX - 8'd1);
      send_item(REQ_CALIBRATE, level_sample(black_l, white_l, 1'b0),
                level_sample(black_r, white_r, 1'b0));
   endtask

   task automatic test_backpressure();
      idle_on = 1'b0;
      rsp_hold_cycles = 200;
      repeat (12)
         send_item(REQ_MEASURE, SAMPLE_BITS'($urandom_range(0, int'(SAMPLE_MAX))),
                   SAMPLE_BITS'($urandom_range(0, int'(SAMPLE_MAX))));
      wait_all_results();
      idle_on = 1'b1;
   endtask

   task automatic test_random_traffic();
      int         phase;
      int         stop_at;
      int         kind;
      bit         paused;
      logic       typ;
      logic [7:0] thresh;
      logic [7:0] timeout;
      paused = 1'b0;
      for (phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin
               thresh = 8'd0;
               timeout = 8'd0;
            end
            1: begin
               thresh = 8'hff;
               timeout = TIMER_MAX - 8'd1;
            end
            default: begin
               thresh = 8'($urandom_range(0, 255));
               timeout = 8'($urandom_range(0, 24));
            end
         endcase
         set_config(thresh, timeout);
         idle_on = (phase != 2);
         stop_at = items_sent + 80;
         while (items_sent < stop_at) begin
            kind = $urandom_range(0, 9);
            if (kind < 6) begin
               // sweep for new extremes, quiet tail, then measure
               repeat ($urandom_range(3, 8))
                  send_item(REQ_CALIBRATE, level_sample(black_l, white_l, 1'b1),
                            level_sample(black_r, white_r, 1'b1));
               repeat ($urandom_range(0, 25))
                  send_item(REQ_CALIBRATE, level_sample(black_l, white_l, 1'b0),
                            level_sample(black_r, white_r, 1'b0));
               repeat ($urandom_range(1, 4))
                  send_item(REQ_MEASURE, meas_sample(black_l, white_l),
                            meas_sample(black_r, white_r));
            end else if (kind < 8) begin
               repeat ($urandom_range(1, 6))
                  send_item(REQ_MEASURE, meas_sample(black_l, white_l),
                            meas_sample(black_r, white_r));
            end else begin
               // broken sequences: measures cut into calibration
               repeat ($urandom_range(1, 6)) begin
                  typ = $urandom_range(0, 1) ? REQ_MEASURE : REQ_CALIBRATE;
                  if (typ == REQ_MEASURE)
                     send_item(typ, SAMPLE_BITS'($urandom_range(0, int'(SAMPLE_MAX))),
                               SAMPLE_BITS'($urandom_range(0, int'(SAMPLE_MAX))));
                  else
                     send_item(typ, level_sample(black_l, white_l, 1'b1),
                               level_sample(black_r, white_r, 1'b1));
               end
            end
            if (phase == 4 && !paused && items_sent >= stop_at - 55) begin
               wait_all_results();
               paused = 1'b1;
            end
         end
      end
      idle_on = 1'b1;
   endtask

   // open the levels to the full sample range
   task automatic test_full_range();
      set_config(DARK_LEVEL_RESET, 8'd0);
      send_item(REQ_CALIBRATE, '0, SAMPLE_MAX);
      send_item(REQ_CALIBRATE, SAMPLE_MAX, '0);
      send_item(REQ_CALIBRATE, SAMPLE_MAX >> 1, SAMPLE_MAX >> 1);
      send_item(REQ_MEASURE, '0, SAMPLE_MAX);
      send_item(REQ_MEASURE, 10'd1, SAMPLE_MAX - 1'b1);
      send_item(REQ_MEASURE, SAMPLE_MAX >> 1, (SAMPLE_MAX >> 1) - 1'b1);
   endtask

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.req_type = REQ_CALIBRATE;
      req_bus.left_sample = '0;
      req_bus.right_sample = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = CSR_DARK_LEVEL;
      csr_bus.data = '0;
      black_l = BLACK_RESET;
      black_r = BLACK_RESET;
      white_l = WHITE_RESET;
      white_r = WHITE_RESET;
      quiet_count = '0;
      extreme_seen = '0;
      held_l = LIGHT_MAX;
      held_r = LIGHT_MAX;
      cfg_dark_level = DARK_LEVEL_RESET;
      cfg_quiet_timeout = QUIET_TIMEOUT_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_reset_outputs();
      test_dark_level();
      test_calibration_done();
      test_timer_saturation();
      test_backpressure();
      test_random_traffic();
      test_full_range();

      wait_all_results();
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && expected_lights.size() == 0) begin
         $display("** line_sensor_calibrate_normalize_unit: PASSED **");
      end else begin
         $display("** line_sensor_calibrate_normalize_unit: FAILED **");
      end
      $finish;
   end

endmodule
